@@ sv/gmmp_pkg.sv @@
// Shared types and constants of the gain map metadata parser.
package gmmp_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_FIELD    = 2'd0,
        STAT_COMPLETE = 2'd1,
        STAT_BADVER   = 2'd2,
        STAT_TRUNC    = 2'd3
    } status_t;

    // Which item of the record the assembler is collecting.
    typedef enum logic [1:0] {
        STG_MINVER = 2'd0,
        STG_WRITER = 2'd1,
        STG_FLAGS  = 2'd2,
        STG_DATA   = 2'd3
    } stage_t;

    // Record phase: parsing, or skipping to the end of the buffer.
    typedef enum logic {
        PH_PARSE = 1'b0,
        PH_SKIP  = 1'b1
    } phase_t;

    // Sequencer state.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EMIT = 1'b1
    } seq_state_t;

    // What the sequencer emits in the current cycle.
    typedef enum logic [2:0] {
        K_NONE = 3'd0,
        K_ERR  = 3'd1,
        K_FA   = 3'd2,
        K_FB   = 3'd3,
        K_REP  = 3'd4,
        K_CMP  = 3'd5,
        K_TRU  = 3'd6
    } kind_t;

    // Results still owed for the current byte, in emission order.
    typedef struct packed {
        logic err;
        logic fa;
        logic fb;
        logic rep;
        logic cmp;
        logic tru;
    } pend_t;

    // Assembler view of the byte being presented.
    typedef struct packed {
        logic        done;
        stage_t      stage;
        logic [31:0] value;
    } asm_t;

    // Field identifiers.
    localparam logic [3:0] FID_HEADROOM_N = 4'd0;
    localparam logic [3:0] FID_MIN_N      = 4'd4;
    localparam logic [3:0] FID_ALT_OFF_N  = 4'd12;
    localparam logic [3:0] FID_ALT_OFF_D  = 4'd13;
    localparam logic [3:0] FID_BASECS     = 4'd14;
    localparam logic [3:0] FID_BACKWARD   = 4'd15;

    // Flags byte bit positions.
    localparam int FLAG_MULTI    = 7;
    localparam int FLAG_BASECS   = 6;
    localparam int FLAG_COMMON   = 3;
    localparam int FLAG_BACKWARD = 2;

    // Per-channel fields held for replay.
    localparam int          STORE_DEPTH = 10;
    localparam logic [3:0]  REP_LAST    = 4'd9;
    localparam logic [1:0]  CH_FIRST    = 2'd0;
    localparam logic [1:0]  CH_SECOND   = 2'd1;
    localparam logic [1:0]  CH_LAST     = 2'd2;

endpackage

@@ sv/gmmp_if.sv @@
// Handshake channels for record bytes and parser results.
interface gmmp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface gmmp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  field_id;
    logic [1:0]  channel;
    logic [31:0] field_value;
    logic        last_of_run;

    modport source (output valid, output status, output field_id, output channel,
                    output field_value, output last_of_run, input ready);
    modport sink   (input valid, input status, input field_id, input channel,
                    input field_value, input last_of_run, output ready);
endinterface

@@ sv/gain_map_metadata_parser_top.sv @@
// Top level of the gain map metadata parser: decode, result sequencer and replay store.
//
//   Channel   Direction  Payload
//   bytes     sink       data_byte[7:0], end_of_buffer
//   results   source     status, field_id, channel, field_value[31:0], last_of_run
//
// A byte is taken while the sequencer is idle. The final item of a single-channel record
// causes the most results, among them 20 replayed values read from the store one a cycle
// while results are not stalled. A byte with no results lets the next byte in on the
// following cycle; otherwise its results are loaded into the output register in turn.
// Reset is asynchronous and active low; the parser then waits for a minimum version.
// A stalled results channel holds the sequencer; no byte is taken until all results
// of the previous byte have been loaded into the output register.
module gain_map_metadata_parser_top (
    input  logic          clk,
    input  logic          rst_n,
    gmmp_byte_if.sink     bytes,
    gmmp_result_if.source results
);

    // Sequencer and record state.
    gmmp_pkg::seq_state_t state_reg, state_next;
    gmmp_pkg::phase_t     phase_reg, phase_next;
    gmmp_pkg::pend_t      pend_reg, pend_next;
    logic                 multi_reg, multi_next;
    logic                 common_reg, common_next;
    logic                 den_seen_reg, den_seen_next;
    logic [31:0]          shared_den_reg, shared_den_next;
    logic [3:0]           pos_fid_reg, pos_fid_next;
    logic [1:0]           pos_ch_reg, pos_ch_next;

    // Latched results of the current byte.
    logic [3:0]           fa_fid_reg, fa_fid_next;
    logic [1:0]           fa_ch_reg, fa_ch_next;
    logic [31:0]          fa_val_reg, fa_val_next;
    logic [3:0]           fb_fid_reg, fb_fid_next;
    logic [31:0]          fb_val_reg, fb_val_next;
    logic [3:0]           rep_fidx_reg, rep_fidx_next;
    logic [1:0]           rep_ch_reg, rep_ch_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [3:0]           out_fid_reg, out_fid_next;
    logic [1:0]           out_ch_reg, out_ch_next;
    logic [31:0]          out_val_reg, out_val_next;
    logic                 out_last_reg, out_last_next;

    // Channel-0 per-channel fields, replayed to channels 1 and 2.
    logic [31:0]          store_mem [gmmp_pkg::STORE_DEPTH];
    logic                 store_we;
    logic [3:0]           store_waddr;
    logic [31:0]          store_wdata;
    logic                 rep_rd;

    gmmp_pkg::asm_t       word;
    gmmp_pkg::kind_t      kind;
    logic                 accept;
    logic                 parse;
    logic                 slot_free;
    logic                 is_last;
    logic [3:0]           wrap_fid;
    logic [1:0]           last_ch;

    assign accept    = bytes.valid && bytes.ready;
    assign parse     = (phase_reg == gmmp_pkg::PH_PARSE);
    assign slot_free = !out_valid_reg || results.ready;
    assign bytes.ready = (state_reg == gmmp_pkg::S_IDLE);

    gmmp_asm u_asm (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept && parse),
        .clear     (accept && bytes.end_of_buffer),
        .data_byte (bytes.data_byte),
        .word      (word)
    );

    // The next result to emit is the first one still owed.
    always_comb
    begin
        if (pend_reg.err)
            kind = gmmp_pkg::K_ERR;
        else if (pend_reg.fa)
            kind = gmmp_pkg::K_FA;
        else if (pend_reg.fb)
            kind = gmmp_pkg::K_FB;
        else if (pend_reg.rep)
            kind = gmmp_pkg::K_REP;
        else if (pend_reg.cmp)
            kind = gmmp_pkg::K_CMP;
        else if (pend_reg.tru)
            kind = gmmp_pkg::K_TRU;
        else
            kind = gmmp_pkg::K_NONE;
    end

    // Position bookkeeping: where the field walk wraps and which channel ends the record.
    assign wrap_fid = common_reg ? gmmp_pkg::FID_ALT_OFF_N : gmmp_pkg::FID_ALT_OFF_D;
    assign last_ch  = multi_reg ? gmmp_pkg::CH_LAST : gmmp_pkg::CH_FIRST;
    assign is_last  = (pos_ch_reg == last_ch) && (pos_fid_reg == wrap_fid);

    // Byte decode, sequencer and output register loading.
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        pend_next       = pend_reg;
        multi_next      = multi_reg;
        common_next     = common_reg;
        den_seen_next   = den_seen_reg;
        shared_den_next = shared_den_reg;
        pos_fid_next    = pos_fid_reg;
        pos_ch_next     = pos_ch_reg;
        fa_fid_next     = fa_fid_reg;
        fa_ch_next      = fa_ch_reg;
        fa_val_next     = fa_val_reg;
        fb_fid_next     = fb_fid_reg;
        fb_val_next     = fb_val_reg;
        rep_fidx_next   = rep_fidx_reg;
        rep_ch_next     = rep_ch_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_status_next = out_status_reg;
        out_fid_next    = out_fid_reg;
        out_ch_next     = out_ch_reg;
        out_val_next    = out_val_reg;
        out_last_next   = out_last_reg;
        store_we        = 1'b0;
        store_waddr     = 4'd0;
        store_wdata     = fa_val_reg;
        rep_rd          = 1'b0;

        case (state_reg)
            gmmp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    pend_next     = '0;
                    rep_fidx_next = 4'd0;
                    rep_ch_next   = gmmp_pkg::CH_SECOND;
                    if (parse && word.done)
                    begin
                        case (word.stage)
                            gmmp_pkg::STG_MINVER:
                            begin
                                if (word.value != 32'd0)
                                begin
                                    pend_next.err = 1'b1;
                                    phase_next    = gmmp_pkg::PH_SKIP;
                                end
                            end
                            gmmp_pkg::STG_WRITER:
                            begin
                                pend_next = '0;
                            end
                            gmmp_pkg::STG_FLAGS:
                            begin
                                multi_next   = word.value[gmmp_pkg::FLAG_MULTI];
                                common_next  = word.value[gmmp_pkg::FLAG_COMMON];
                                fa_fid_next  = gmmp_pkg::FID_BASECS;
                                fa_ch_next   = gmmp_pkg::CH_FIRST;
                                fa_val_next  = {31'd0, word.value[gmmp_pkg::FLAG_BASECS]};
                                fb_fid_next  = gmmp_pkg::FID_BACKWARD;
                                fb_val_next  = {31'd0, word.value[gmmp_pkg::FLAG_BACKWARD]};
                                pend_next.fa = 1'b1;
                                pend_next.fb = 1'b1;
                            end
                            gmmp_pkg::STG_DATA:
                            begin
                                if (common_reg && !den_seen_reg)
                                begin
                                    // The shared denominator itself is only stored.
                                    shared_den_next = word.value;
                                    den_seen_next   = 1'b1;
                                end
                                else
                                begin
                                    fa_fid_next  = pos_fid_reg;
                                    fa_ch_next   = pos_ch_reg;
                                    fa_val_next  = word.value;
                                    fb_fid_next  = pos_fid_reg + 4'd1;
                                    fb_val_next  = shared_den_reg;
                                    pend_next.fa = 1'b1;
                                    pend_next.fb = common_reg;
                                    // Walk to the next field position, skipping the denominator when it is shared.
                                    if (pos_fid_reg == wrap_fid)
                                    begin
                                        pos_fid_next = gmmp_pkg::FID_MIN_N;
                                        pos_ch_next  = pos_ch_reg + 2'd1;
                                    end
                                    else
                                    begin
                                        pos_fid_next = pos_fid_reg + (common_reg ? 4'd2 : 4'd1);
                                    end
                                    if (is_last)
                                    begin
                                        pend_next.rep = !multi_reg;
                                        pend_next.cmp = 1'b1;
                                        phase_next    = gmmp_pkg::PH_SKIP;
                                    end
                                end
                            end
                            default:
                            begin
                                pend_next = '0;
                            end
                        endcase
                    end
                    // A buffer that ends while still parsing leaves the record truncated.
                    if (parse && bytes.end_of_buffer && phase_next == gmmp_pkg::PH_PARSE)
                        pend_next.tru = 1'b1;
                    // End of buffer rearms the parser for the next record.
                    if (bytes.end_of_buffer)
                    begin
                        phase_next    = gmmp_pkg::PH_PARSE;
                        den_seen_next = 1'b0;
                        pos_fid_next  = gmmp_pkg::FID_HEADROOM_N;
                        pos_ch_next   = gmmp_pkg::CH_FIRST;
                    end
                    if (pend_next != '0)
                        state_next = gmmp_pkg::S_EMIT;
                end
            end
            gmmp_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = gmmp_pkg::STAT_FIELD;
                    out_fid_next    = 4'd0;
                    out_ch_next     = 2'd0;
                    out_val_next    = 32'd0;
                    case (kind)
                        gmmp_pkg::K_ERR:
                        begin
                            out_status_next = gmmp_pkg::STAT_BADVER;
                            pend_next.err   = 1'b0;
                        end
                        gmmp_pkg::K_FA:
                        begin
                            out_fid_next = fa_fid_reg;
                            out_ch_next  = fa_ch_reg;
                            out_val_next = fa_val_reg;
                            pend_next.fa = 1'b0;
                            store_wdata  = fa_val_reg;
                            store_waddr  = fa_fid_reg - gmmp_pkg::FID_MIN_N;
                            store_we     = (fa_ch_reg == gmmp_pkg::CH_FIRST)
                                           && (fa_fid_reg >= gmmp_pkg::FID_MIN_N)
                                           && (fa_fid_reg <= gmmp_pkg::FID_ALT_OFF_D);
                        end
                        gmmp_pkg::K_FB:
                        begin
                            out_fid_next = fb_fid_reg;
                            out_ch_next  = fa_ch_reg;
                            out_val_next = fb_val_reg;
                            pend_next.fb = 1'b0;
                            store_wdata  = fb_val_reg;
                            store_waddr  = fb_fid_reg - gmmp_pkg::FID_MIN_N;
                            store_we     = (fa_ch_reg == gmmp_pkg::CH_FIRST)
                                           && (fb_fid_reg >= gmmp_pkg::FID_MIN_N)
                                           && (fb_fid_reg <= gmmp_pkg::FID_ALT_OFF_D);
                        end
                        gmmp_pkg::K_REP:
                        begin
                            out_fid_next = gmmp_pkg::FID_MIN_N + rep_fidx_reg;
                            out_ch_next  = rep_ch_reg;
                            rep_rd       = 1'b1;
                            if (rep_fidx_reg == gmmp_pkg::REP_LAST)
                            begin
                                rep_fidx_next = 4'd0;
                                rep_ch_next   = rep_ch_reg + 2'd1;
                                if (rep_ch_reg == gmmp_pkg::CH_LAST)
                                    pend_next.rep = 1'b0;
                            end
                            else
                            begin
                                rep_fidx_next = rep_fidx_reg + 4'd1;
                            end
                        end
                        gmmp_pkg::K_CMP:
                        begin
                            out_status_next = gmmp_pkg::STAT_COMPLETE;
                            pend_next.cmp   = 1'b0;
                        end
                        gmmp_pkg::K_TRU:
                        begin
                            out_status_next = gmmp_pkg::STAT_TRUNC;
                            pend_next.tru   = 1'b0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b0;
                        end
                    endcase
                    out_last_next = (pend_next == '0);
                    if (pend_next == '0)
                        state_next = gmmp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gmmp_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gmmp_pkg::S_IDLE;
            phase_reg      <= gmmp_pkg::PH_PARSE;
            pend_reg       <= '0;
            multi_reg      <= 1'b0;
            common_reg     <= 1'b0;
            den_seen_reg   <= 1'b0;
            shared_den_reg <= 32'd1;
            pos_fid_reg    <= gmmp_pkg::FID_HEADROOM_N;
            pos_ch_reg     <= gmmp_pkg::CH_FIRST;
            rep_fidx_reg   <= 4'd0;
            rep_ch_reg     <= gmmp_pkg::CH_SECOND;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            pend_reg       <= pend_next;
            multi_reg      <= multi_next;
            common_reg     <= common_next;
            den_seen_reg   <= den_seen_next;
            shared_den_reg <= shared_den_next;
            pos_fid_reg    <= pos_fid_next;
            pos_ch_reg     <= pos_ch_next;
            rep_fidx_reg   <= rep_fidx_next;
            rep_ch_reg     <= rep_ch_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        fa_fid_reg     <= fa_fid_next;
        fa_ch_reg      <= fa_ch_next;
        fa_val_reg     <= fa_val_next;
        fb_fid_reg     <= fb_fid_next;
        fb_val_reg     <= fb_val_next;
        out_status_reg <= out_status_next;
        out_fid_reg    <= out_fid_next;
        out_ch_reg     <= out_ch_next;
        out_last_reg   <= out_last_next;
    end

    // Replay store: channel-0 writes, and replayed values read straight into the output register.
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_waddr] <= store_wdata;
        if (rep_rd)
            out_val_reg <= store_mem[rep_fidx_reg];
        else
            out_val_reg <= out_val_next;
    end

    assign results.valid       = out_valid_reg;
    assign results.status      = out_status_reg;
    assign results.field_id    = out_fid_reg;
    assign results.channel     = out_ch_reg;
    assign results.field_value = out_val_reg;
    assign results.last_of_run = out_last_reg;

    // The sequencer only returns to idle once every owed result has been loaded into the output register.
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gmmp_pkg::S_IDLE |-> pend_reg == '0)
        else $error("idle with results still owed");

    // A completion, bad-version or truncation result always closes the run of its byte.
    a_status_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.status == gmmp_pkg::STAT_COMPLETE
                          || results.status == gmmp_pkg::STAT_BADVER
                          || results.status == gmmp_pkg::STAT_TRUNC)
        |-> results.last_of_run)
        else $error("status result not marked last");

    // Replay only ever targets channels 1 and 2.
    a_replay_channel: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg.rep |-> rep_ch_reg != gmmp_pkg::CH_FIRST)
        else $error("replay on channel 0");

    // Any byte that ends the buffer rearms the parser.
    a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        accept && bytes.end_of_buffer |=> phase_reg == gmmp_pkg::PH_PARSE && !den_seen_reg)
        else $error("parser not rearmed after end of buffer");

endmodule

@@ sv/gmmp_asm.sv @@
// Byte assembler: collects big-endian record items and tracks the record stage.
module gmmp_asm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic           clear,
    input  logic [7:0]     data_byte,
    output gmmp_pkg::asm_t word
);

    gmmp_pkg::stage_t stage_reg, stage_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [23:0]      shift_reg, shift_next;
    logic             done;

    // The item is complete on its last byte; its length depends on the stage.
    always_comb
    begin
        case (stage_reg)
            gmmp_pkg::STG_MINVER: done = (cnt_reg == 2'd1);
            gmmp_pkg::STG_WRITER: done = (cnt_reg == 2'd1);
            gmmp_pkg::STG_FLAGS:  done = 1'b1;
            gmmp_pkg::STG_DATA:   done = (cnt_reg == 2'd3);
            default:              done = 1'b1;
        endcase
    end

    assign word.done  = done;
    assign word.stage = stage_reg;
    assign word.value = {shift_reg, data_byte};

    // Next stage, byte count and shift contents.
    always_comb
    begin
        stage_next = stage_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        if (clear)
        begin
            stage_next = gmmp_pkg::STG_MINVER;
            cnt_next   = 2'd0;
            shift_next = 24'd0;
        end
        else if (step)
        begin
            if (done)
            begin
                cnt_next   = 2'd0;
                shift_next = 24'd0;
                case (stage_reg)
                    gmmp_pkg::STG_MINVER: stage_next = gmmp_pkg::STG_WRITER;
                    gmmp_pkg::STG_WRITER: stage_next = gmmp_pkg::STG_FLAGS;
                    gmmp_pkg::STG_FLAGS:  stage_next = gmmp_pkg::STG_DATA;
                    gmmp_pkg::STG_DATA:   stage_next = gmmp_pkg::STG_DATA;
                    default:              stage_next = gmmp_pkg::STG_MINVER;
                endcase
            end
            else
            begin
                cnt_next   = cnt_reg + 2'd1;
                shift_next = {shift_reg[15:0], data_byte};
            end
        end
    end

    // Assembler registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= gmmp_pkg::STG_MINVER;
            cnt_reg   <= 2'd0;
            shift_reg <= 24'd0;
        end
        else
        begin
            stage_reg <= stage_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
        end
    end

endmodule
